/* hdl/gqp_pkg.sv */
// shared types, constants and helper functions for the gyro quaternion propagation block
package gqp_pkg;

  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Z    = 3'd4;

  localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;
  localparam logic signed [31:0] INIT_W_RESET = 32'sd1073741824;

  typedef struct packed {
    logic               func;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               degenerate;
  } result_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_HALF,
    OP_SQR,
    OP_ROOT,
    OP_CHK,
    OP_DIV,
    OP_HAM,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
  } cmd_t;

  typedef struct packed {
    logic norm_low;
  } sts_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sign of hamilton product term j of output component o
  function automatic logic ham_neg(input logic [1:0] o, input logic [1:0] j);
    logic r;
    case (o)
      2'd0: r = (j != 2'd0);
      2'd1: r = (j == 2'd3);
      2'd2: r = (j == 2'd1);
      2'd3: r = (j == 2'd2);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/gqp_ctrl.sv */
// sequencing state machine for the gyro quaternion propagation block
module gqp_ctrl #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  input  logic          sample_func,
  output logic          sample_ready,
  output logic          result_valid,
  input  logic          result_ready,
  input  gqp_pkg::sts_t sts,
  output gqp_pkg::cmd_t cmd
);

  localparam int DW = 32 + QUAT_FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_HALF = 9'b000000010,
    S_SQR  = 9'b000000100,
    S_ROOT = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_HAM  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [gqp_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [1:0] comp, comp_next;
  logic pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      comp  <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    comp_next  = comp;
    pass_next  = pass;
    cmd.op     = gqp_pkg::OP_IDLE;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (sample_valid) begin
          cmd.op     = gqp_pkg::OP_LOAD;
          pass_next  = sample_func;
          state_next = sample_func ? S_SQR : S_HALF;
        end
      end
      S_HALF: begin
        cmd.op = gqp_pkg::OP_HALF;
        if (cnt == gqp_pkg::CNT_W'(3)) begin
          cnt_next   = '0;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        cmd.op = gqp_pkg::OP_SQR;
        if (cnt == gqp_pkg::CNT_W'(4)) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.op = gqp_pkg::OP_ROOT;
        if (cnt == gqp_pkg::CNT_W'(32)) begin
          cnt_next   = '0;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.op    = gqp_pkg::OP_CHK;
        cnt_next  = '0;
        comp_next = '0;
        if (!sts.norm_low) begin
          state_next = S_DIV;
        end else begin
          state_next = pass ? S_FIN : S_HAM;
        end
      end
      S_DIV: begin
        cmd.op = gqp_pkg::OP_DIV;
        if (cnt == gqp_pkg::CNT_W'(DW + 1)) begin
          cnt_next = '0;
          if (comp == 2'd3) begin
            state_next = pass ? S_FIN : S_HAM;
          end else begin
            comp_next = comp + 1'b1;
          end
        end
      end
      S_HAM: begin
        cmd.op = gqp_pkg::OP_HAM;
        if (cnt == gqp_pkg::CNT_W'(16)) begin
          cnt_next   = '0;
          pass_next  = 1'b1;
          state_next = S_SQR;
        end
      end
      S_FIN: begin
        cmd.op     = gqp_pkg::OP_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.cnt  = cnt;
    cmd.comp = comp;
  end

  assign sample_ready = (state == S_IDLE);
  assign result_valid = (state == S_DONE);

endmodule

/* hdl/gqp_dp.sv */
// datapath: registers, shared multiplier, square root and divider for quaternion update
module gqp_dp #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gqp_pkg::cmd_t                    cmd,
  output gqp_pkg::sts_t                    sts,
  input  gqp_pkg::sample_t                 sample,
  input  logic                             cfg_we,
  input  logic [gqp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  output gqp_pkg::result_t                 result
);

  localparam int DW = 32 + QUAT_FRAC_BITS;
  localparam int SH = 59 - QUAT_FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'(64'd1 << QUAT_FRAC_BITS);
  localparam logic [63:0] THR = 64'((64'd1 << QUAT_FRAC_BITS) / 1000000);

  logic [31:0] time_step;
  logic signed [31:0] init_q [4];
  logic signed [31:0] rate [3];
  logic signed [31:0] vec [4];
  logic signed [31:0] att [4];
  logic signed [31:0] res [4];
  logic deg;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] acc;
  logic signed [66:0] prod_x, term, ham_sum;
  logic [1:0] tj, to;
  logic tneg;

  logic [63:0] sv, rt, bt, rb;
  logic [31:0] rem;
  logic [DW-1:0] quo;
  logic qneg;
  logic [32:0] trial;
  logic [31:0] mag;

  logic [1:0] ci, ho, hj;
  logic signed [31:0] rate_sel;

  assign ci = cmd.cnt[1:0];
  assign ho = cmd.cnt[3:2];
  assign hj = cmd.cnt[1:0];
  assign prod_x = {prod[65], prod};
  assign term = tneg ? -prod_x : prod_x;
  assign ham_sum = ((tj == 2'd0) ? 67'sd0 : acc) + term;
  assign rb = rt + bt;
  assign trial = {rem, quo[DW-1]};
  assign mag = vec[cmd.comp][31] ? (~vec[cmd.comp] + 32'd1) : vec[cmd.comp];
  assign sts.norm_low = (rt <= THR);

  always_comb begin
    case (ci)
      2'd0: rate_sel = rate[0];
      2'd1: rate_sel = rate[1];
      2'd2: rate_sel = rate[2];
      default: rate_sel = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      gqp_pkg::OP_HALF: begin
        mul_a = {rate_sel[31], rate_sel};
        mul_b = {1'b0, time_step};
      end
      gqp_pkg::OP_SQR: begin
        mul_a = {vec[ci][31], vec[ci]};
        mul_b = {vec[ci][31], vec[ci]};
      end
      gqp_pkg::OP_HAM: begin
        mul_a = {att[hj][31], att[hj]};
        mul_b = {res[hj ^ ho][31], res[hj ^ ho]};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= gqp_pkg::TIME_STEP_RESET;
      init_q[0] <= gqp_pkg::INIT_W_RESET;
      init_q[1] <= '0;
      init_q[2] <= '0;
      init_q[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gqp_pkg::REG_TIME_STEP: time_step <= cfg_data;
        gqp_pkg::REG_INIT_W:    init_q[0] <= cfg_data;
        gqp_pkg::REG_INIT_X:    init_q[1] <= cfg_data;
        gqp_pkg::REG_INIT_Y:    init_q[2] <= cfg_data;
        gqp_pkg::REG_INIT_Z:    init_q[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // attitude state and degenerate flag
  always_ff @(posedge clk) begin
    if (rst) begin
      att[0] <= ONE;
      att[1] <= '0;
      att[2] <= '0;
      att[3] <= '0;
      deg    <= 1'b0;
    end else begin
      if (cmd.op == gqp_pkg::OP_FIN) begin
        att <= res;
      end
      if (cmd.op == gqp_pkg::OP_LOAD) begin
        deg <= 1'b0;
      end else if (cmd.op == gqp_pkg::OP_CHK && sts.norm_low) begin
        deg <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      gqp_pkg::OP_LOAD: begin
        rate[0] <= sample.rate_x;
        rate[1] <= sample.rate_y;
        rate[2] <= sample.rate_z;
        vec     <= init_q;
      end
      gqp_pkg::OP_HALF: begin
        vec[ci] <= (cmd.cnt == '0) ? ONE : gqp_pkg::sat32(67'(prod >>> SH));
      end
      gqp_pkg::OP_SQR: begin
        if (cmd.cnt == gqp_pkg::CNT_W'(1)) begin
          acc <= prod_x;
        end else if (cmd.cnt != '0) begin
          acc <= acc + prod_x;
        end
      end
      gqp_pkg::OP_ROOT: begin
        if (cmd.cnt == '0) begin
          sv <= (acc[66:64] != 3'd0) ? '1 : acc[63:0];
          rt <= '0;
          bt <= 64'd1 << 62;
        end else begin
          if (sv >= rb) begin
            sv <= sv - rb;
            rt <= (rt >> 1) + bt;
          end else begin
            rt <= rt >> 1;
          end
          bt <= bt >> 2;
        end
      end
      gqp_pkg::OP_CHK: begin
        if (sts.norm_low) begin
          res[0] <= ONE;
          res[1] <= '0;
          res[2] <= '0;
          res[3] <= '0;
        end
      end
      gqp_pkg::OP_DIV: begin
        if (cmd.cnt == '0) begin
          rem  <= '0;
          quo  <= {mag, {QUAT_FRAC_BITS{1'b0}}};
          qneg <= vec[cmd.comp][31];
        end else if (cmd.cnt == gqp_pkg::CNT_W'(DW + 1)) begin
          if (qneg) begin
            res[cmd.comp] <= (quo > DW'(64'h80000000)) ? 32'sh80000000 : -quo[31:0];
          end else begin
            res[cmd.comp] <= (quo > DW'(64'h7fffffff)) ? 32'sh7fffffff : quo[31:0];
          end
        end else begin
          if (trial >= {1'b0, rt[31:0]}) begin
            rem <= 32'(trial - {1'b0, rt[31:0]});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
        end
      end
      gqp_pkg::OP_HAM: begin
        tj   <= hj;
        to   <= ho;
        tneg <= gqp_pkg::ham_neg(ho, hj);
        if (cmd.cnt != '0) begin
          acc <= ham_sum;
          if (tj == 2'd3) begin
            vec[to] <= gqp_pkg::sat32(ham_sum >>> QUAT_FRAC_BITS);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result.att_w      = att[0];
  assign result.att_x      = att[1];
  assign result.att_y      = att[2];
  assign result.att_z      = att[3];
  assign result.degenerate = deg;

endmodule

/* hdl/gyro_quaternion_propagation.sv */
// top level of the gyro quaternion propagation block
//
//  channel  signals                              dir  beat
//  sample   sample_valid sample_ready sample     in   func and three rates
//  result   result_valid result_ready result     out  attitude and degenerate flag
//  cfg      cfg_valid cfg_ready cfg_index/data   in   one register write
//
// one sample at a time; from the accepting edge a propagation at Q2.30 runs
// the increment, then squares, root, check and divide, then the product, then
// squares, root, check and divide again, then the commit; a reload runs only
// squares, root, check, divide and commit; a norm at or below threshold skips
// its divide; the square root and divider are bit-serial
// synchronous reset restores identity attitude and register defaults
// result holds until taken; the next sample is taken the cycle after the result beat
module gyro_quaternion_propagation #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  gqp_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output gqp_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gqp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  gqp_pkg::cmd_t cmd;
  gqp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gqp_ctrl #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_func  (sample.func),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  gqp_dp #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (sample),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
